/* rtl/teb_pkg.sv */
// Text edit buffer package: command codes and the transaction payload types.
// No dependencies; used by text_edit_buffer_with_cursor.
package teb_pkg;

  // Command codes carried in the kind field
  localparam logic [3:0] KIND_INSERT   = 4'd0;
  localparam logic [3:0] KIND_DELETE   = 4'd1;
  localparam logic [3:0] KIND_FORWARD  = 4'd2;
  localparam logic [3:0] KIND_BACKWARD = 4'd3;
  localparam logic [3:0] KIND_START    = 4'd4;
  localparam logic [3:0] KIND_END      = 4'd5;
  localparam logic [3:0] KIND_COPY     = 4'd6;
  localparam logic [3:0] KIND_PASTE    = 4'd7;
  localparam logic [3:0] KIND_READ     = 4'd8;

  // Command transaction
  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] char_in;
    logic [8:0] copy_count;
    logic [7:0] read_index;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic [8:0] cursor_out;
    logic [8:0] length_out;
    logic [7:0] read_char;
    logic       read_valid;
    logic       overflow;
  } out_t;

endpackage

/* rtl/teb_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module teb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    // read data holds until the next read
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/text_edit_buffer_with_cursor.sv */
// Text edit buffer with cursor; needs teb_pkg and teb_ram. One command at a time: in_stall is
// high from accept until the result is registered, and a stalled result holds the finish state.
// Each command runs byte passes through the move engine between setup and finish. Cursor
// moves, read and no-op run one empty pass; insert, delete and copy one pass of the
// tail, the tail less one and the copied bytes; paste two, the tail and then the pasted bytes.
// Synchronous active-low reset clears cursor, length, clip length and control, not the RAMs.
module text_edit_buffer_with_cursor #(
  parameter int CAPACITY = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  teb_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output teb_pkg::out_t out_data
);

  localparam int LW = $clog2(CAPACITY + 1);   // length / cursor width
  localparam int AW = $clog2(CAPACITY);       // RAM address width
  localparam int CW = (LW > 9) ? LW : 9;      // compare width vs. 9-bit fields

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SETUP = 4'b0010,
    S_MOVE  = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t        state_r, state_nxt;
  teb_pkg::in_t  cmd_r, cmd_nxt;
  logic [LW-1:0] cur_r, cur_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] clip_len_r, clip_len_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic [LW-1:0] amt_r, amt_nxt;
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic [AW-1:0] prev_addr_r, prev_addr_nxt;
  logic [AW-1:0] delta_r, delta_nxt;
  logic          pend_r, pend_nxt;
  logic          desc_r, desc_nxt;
  logic          src_clip_r, src_clip_nxt;
  logic          dst_clip_r, dst_clip_nxt;
  logic          phase_r, phase_nxt;
  logic          ovf_r, ovf_nxt;
  logic          rvalid_r, rvalid_nxt;
  logic          out_valid_r, out_valid_nxt;
  teb_pkg::out_t out_r, out_nxt;

  // RAM ports
  logic          text_we, text_re, clip_we, clip_re;
  logic [AW-1:0] text_waddr, text_raddr, clip_waddr, clip_raddr;
  logic [7:0]    text_wdata, text_rdata, clip_wdata, clip_rdata;
  logic [7:0]    mv_data;
  logic [AW-1:0] mv_waddr;

  // Setup arithmetic
  logic [LW-1:0] avail;
  logic [LW-1:0] copy_n;
  logic [LW-1:0] room;
  logic [LW-1:0] paste_k;
  logic          rd_ok;
  logic [LW-1:0] cur_new, len_new;

  assign avail   = len_r - cur_r;
  assign copy_n  = (CW'(cmd_r.copy_count) > CW'(avail)) ? avail : LW'(cmd_r.copy_count);
  assign room    = LW'(CAPACITY) - len_r;
  assign paste_k = (clip_len_r > room) ? room : clip_len_r;
  assign rd_ok   = CW'(cmd_r.read_index) < CW'(len_r);

  assign mv_data  = src_clip_r ? clip_rdata : text_rdata;
  assign mv_waddr = prev_addr_r + delta_r;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  teb_ram #(.WIDTH(8), .DEPTH(CAPACITY)) u_text_ram (
    .clk     (clk),
    .wr_en   (text_we),
    .wr_addr (text_waddr),
    .wr_data (text_wdata),
    .rd_en   (text_re),
    .rd_addr (text_raddr),
    .rd_data (text_rdata)
  );

  teb_ram #(.WIDTH(8), .DEPTH(CAPACITY)) u_clip_ram (
    .clk     (clk),
    .wr_en   (clip_we),
    .wr_addr (clip_waddr),
    .wr_data (clip_wdata),
    .rd_en   (clip_re),
    .rd_addr (clip_raddr),
    .rd_data (clip_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    cur_nxt       = cur_r;
    len_nxt       = len_r;
    clip_len_nxt  = clip_len_r;
    cnt_nxt       = cnt_r;
    amt_nxt       = amt_r;
    rd_addr_nxt   = rd_addr_r;
    prev_addr_nxt = prev_addr_r;
    delta_nxt     = delta_r;
    pend_nxt      = pend_r;
    desc_nxt      = desc_r;
    src_clip_nxt  = src_clip_r;
    dst_clip_nxt  = dst_clip_r;
    phase_nxt     = phase_r;
    ovf_nxt       = ovf_r;
    rvalid_nxt    = rvalid_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    cur_new       = cur_r;
    len_new       = len_r;

    text_we    = 1'b0;
    text_waddr = mv_waddr;
    text_wdata = mv_data;
    text_re    = 1'b0;
    text_raddr = rd_addr_r;
    clip_we    = 1'b0;
    clip_waddr = mv_waddr;
    clip_wdata = mv_data;
    clip_re    = 1'b0;
    clip_raddr = rd_addr_r;

    // result register drains independently
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_data;
          state_nxt = S_SETUP;
        end
      end

      // load the move engine for this command
      S_SETUP: begin
        cnt_nxt      = '0;
        pend_nxt     = 1'b0;
        desc_nxt     = 1'b0;
        src_clip_nxt = 1'b0;
        dst_clip_nxt = 1'b0;
        phase_nxt    = 1'b0;
        ovf_nxt      = 1'b0;
        rvalid_nxt   = 1'b0;
        amt_nxt      = '0;
        delta_nxt    = '0;
        rd_addr_nxt  = '0;
        case (cmd_r.kind)
          teb_pkg::KIND_INSERT: begin
            if (len_r == LW'(CAPACITY)) begin
              ovf_nxt = 1'b1;
            end else begin
              // open a gap at the cursor: shift tail up by one, top first
              rd_addr_nxt = AW'(len_r - LW'(1));
              cnt_nxt     = avail;
              delta_nxt   = AW'(1);
              desc_nxt    = 1'b1;
            end
          end
          teb_pkg::KIND_DELETE: begin
            if (cur_r < len_r) begin
              // close the gap: shift tail down by one, bottom first
              rd_addr_nxt = AW'(cur_r + LW'(1));
              cnt_nxt     = avail - LW'(1);
              delta_nxt   = '1;
            end
          end
          teb_pkg::KIND_COPY: begin
            rd_addr_nxt  = AW'(cur_r);
            cnt_nxt      = copy_n;
            delta_nxt    = AW'(0) - AW'(cur_r);
            dst_clip_nxt = 1'b1;
            amt_nxt      = copy_n;
          end
          teb_pkg::KIND_PASTE: begin
            // first pass shifts the tail up by the bytes that fit
            rd_addr_nxt = AW'(len_r - LW'(1));
            cnt_nxt     = avail;
            delta_nxt   = AW'(paste_k);
            desc_nxt    = 1'b1;
            amt_nxt     = paste_k;
            ovf_nxt     = clip_len_r > room;
          end
          teb_pkg::KIND_READ: begin
            text_re    = rd_ok;
            text_raddr = AW'(cmd_r.read_index);
            rvalid_nxt = rd_ok;
          end
          default: begin
          end
        endcase
        state_nxt = S_MOVE;
      end

      // one byte read and one byte written per cycle
      S_MOVE: begin
        if (cnt_r != '0) begin
          text_re       = !src_clip_r;
          clip_re       = src_clip_r;
          rd_addr_nxt   = desc_r ? rd_addr_r - AW'(1) : rd_addr_r + AW'(1);
          cnt_nxt       = cnt_r - LW'(1);
          prev_addr_nxt = rd_addr_r;
          pend_nxt      = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          text_we = !dst_clip_r;
          clip_we = dst_clip_r;
        end
        if (cnt_r == '0 && !pend_r) begin
          if (cmd_r.kind == teb_pkg::KIND_PASTE && !phase_r) begin
            // second pass drops the clipboard into the gap
            phase_nxt    = 1'b1;
            src_clip_nxt = 1'b1;
            dst_clip_nxt = 1'b0;
            rd_addr_nxt  = '0;
            cnt_nxt      = amt_r;
            delta_nxt    = AW'(cur_r);
            desc_nxt     = 1'b0;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end

      // commit state and load the result register
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          case (cmd_r.kind)
            teb_pkg::KIND_INSERT: begin
              if (!ovf_r) begin
                text_we    = 1'b1;
                text_waddr = AW'(cur_r);
                text_wdata = cmd_r.char_in;
                cur_new    = cur_r + LW'(1);
                len_new    = len_r + LW'(1);
              end
            end
            teb_pkg::KIND_DELETE: begin
              if (cur_r < len_r) begin
                len_new = len_r - LW'(1);
              end
            end
            teb_pkg::KIND_FORWARD: begin
              if (cur_r < len_r) begin
                cur_new = cur_r + LW'(1);
              end
            end
            teb_pkg::KIND_BACKWARD: begin
              if (cur_r != '0) begin
                cur_new = cur_r - LW'(1);
              end
            end
            teb_pkg::KIND_START: cur_new = '0;
            teb_pkg::KIND_END:   cur_new = len_r;
            teb_pkg::KIND_COPY:  clip_len_nxt = amt_r;
            teb_pkg::KIND_PASTE: begin
              cur_new = cur_r + amt_r;
              len_new = len_r + amt_r;
            end
            default: begin
            end
          endcase
          cur_nxt            = cur_new;
          len_nxt            = len_new;
          out_nxt.cursor_out = 9'(cur_new);
          out_nxt.length_out = 9'(len_new);
          out_nxt.read_char  = rvalid_r ? text_rdata : 8'd0;
          out_nxt.read_valid = rvalid_r;
          out_nxt.overflow   = ovf_r;
          out_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      len_r       <= '0;
      clip_len_r  <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      len_r       <= len_nxt;
      clip_len_r  <= clip_len_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    amt_r       <= amt_nxt;
    rd_addr_r   <= rd_addr_nxt;
    prev_addr_r <= prev_addr_nxt;
    delta_r     <= delta_nxt;
    desc_r      <= desc_nxt;
    src_clip_r  <= src_clip_nxt;
    dst_clip_r  <= dst_clip_nxt;
    ovf_r       <= ovf_nxt;
    rvalid_r    <= rvalid_nxt;
    out_r       <= out_nxt;
  end

endmodule
